### hdl/gcd_lcm_unit_core_macros.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core assertion macros
// concurrent assertion helpers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_CORE_MACROS_SVH
`define GCD_LCM_UNIT_CORE_MACROS_SVH

`ifndef SYNTH
`define GLU_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define GLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GLU_ASSERT(lbl, clk, rst_n, expr)
`define GLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/glu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_pkg
// shared types and constants of the gcd / lcm unit
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int DATA_W = 64;
    localparam int WIDTH  = 64;
    localparam int CNT_W  = $clog2(WIDTH);

    localparam logic FUNC_GCD = 1'b0;
    localparam logic FUNC_LCM = 1'b1;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic gcd;
        logic div;
        logic mul;
        logic emit;
        logic busy;
    } t_ctrl;

    typedef struct packed {
        logic gcd_done;
        logic need_div;
        logic cnt_last;
        logic out_free;
    } t_status;

endpackage

### hdl/gcd_lcm_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core
// gcd or lcm of two unsigned operands on one shared add / subtract unit
// ----------------------------------------------------------------------------
// gcd is a data dependent binary shift-subtract loop,
//   one step per cycle through the shared adder
// lcm of two nonzero operands adds a restoring divide and a shift-add multiply
// plus a step to accept and one to hand the result to the output register
// one item at a time; the next item is taken once the result is registered
// reset is synchronous active low and clears the sequencer and output valid
`include "gcd_lcm_unit_core_macros.svh"

module gcd_lcm_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  glu_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output glu_pkg::t_out_item o_out_data
);
    import glu_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    logic              r_func;
    logic              r_zero;
    logic [WIDTH-1:0]  r_a;
    logic [WIDTH-1:0]  r_b;
    logic [WIDTH-1:0]  r_x;
    logic [WIDTH-1:0]  r_y;
    logic [CNT_W-1:0]  r_k;
    logic [WIDTH-1:0]  r_g;
    logic [WIDTH-1:0]  r_rem;
    logic [WIDTH-1:0]  r_q;
    logic [2*WIDTH-1:0] r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDTH-1:0]  r_res;
    logic              r_ovf;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic [WIDTH:0]    alu_a;
    logic [WIDTH:0]    alu_b;
    logic              alu_sub;
    logic [WIDTH+1:0]  alu_sum;
    logic              borrow;

    logic              x_zero;
    logic              y_zero;
    logic [WIDTH-1:0]  g_val;
    logic [WIDTH:0]    div_t;
    logic [WIDTH-1:0]  n_rem;
    logic [WIDTH-1:0]  n_q;
    logic [2*WIDTH-1:0] n_acc;

    glu_alu u_alu (
        .i_op_a (alu_a),
        .i_op_b (alu_b),
        .i_sub  (alu_sub),
        .o_sum  (alu_sum)
    );

    glu_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    assign o_in_stall  = ctrl.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign x_zero = (r_x == '0);
    assign y_zero = (r_y == '0);
    assign g_val  = (x_zero ? r_y : r_x) << r_k;
    assign borrow = alu_sum[WIDTH+1];
    assign div_t  = {r_rem, r_q[WIDTH-1]};

    assign status.gcd_done = x_zero || y_zero;
    assign status.need_div = (r_func == FUNC_LCM) && !r_zero;
    assign status.cnt_last = (r_cnt == CNT_W'(WIDTH - 1));
    assign status.out_free = !r_out_valid || !i_out_stall;

    // shared adder operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        if (ctrl.gcd) begin
            alu_a = {1'b0, r_x};
            alu_b = {1'b0, r_y};
        end else if (ctrl.div) begin
            alu_a = div_t;
            alu_b = {1'b0, r_g};
        end else if (ctrl.mul) begin
            alu_a   = {1'b0, r_acc[2*WIDTH-1:WIDTH]};
            alu_b   = r_acc[0] ? {1'b0, r_b} : '0;
            alu_sub = 1'b0;
        end
    end

    always_comb begin
        if (borrow) begin
            n_rem = div_t[WIDTH-1:0];
        end else begin
            n_rem = alu_sum[WIDTH-1:0];
        end
        n_q   = {r_q[WIDTH-2:0], !borrow};
        n_acc = {alu_sum[WIDTH:0], r_acc[WIDTH-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_func <= i_in_data.func;
            r_a    <= i_in_data.operand_a[WIDTH-1:0];
            r_b    <= i_in_data.operand_b[WIDTH-1:0];
            r_x    <= i_in_data.operand_a[WIDTH-1:0];
            r_y    <= i_in_data.operand_b[WIDTH-1:0];
            r_zero <= (i_in_data.operand_a[WIDTH-1:0] == '0)
                   || (i_in_data.operand_b[WIDTH-1:0] == '0);
            r_k    <= '0;
        end
        if (ctrl.gcd) begin
            if (x_zero || y_zero) begin
                r_g   <= g_val;
                r_rem <= '0;
                r_q   <= r_a;
                r_cnt <= '0;
                r_res <= (r_func == FUNC_GCD) ? g_val : '0;
                r_ovf <= 1'b0;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + CNT_W'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (borrow) begin
                r_x <= r_y;
                r_y <= r_x;
            end else begin
                r_x <= alu_sum[WIDTH-1:0];
            end
        end
        if (ctrl.div) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            if (status.cnt_last) begin
                r_cnt <= '0;
                r_acc <= {{WIDTH{1'b0}}, n_q};
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (ctrl.mul) begin
            r_acc <= n_acc;
            r_cnt <= r_cnt + CNT_W'(1);
            if (status.cnt_last) begin
                r_res <= n_acc[WIDTH-1:0];
                r_ovf <= (n_acc[2*WIDTH-1:WIDTH] != '0);
            end
        end
        if (ctrl.emit) begin
            r_out_data.result   <= DATA_W'(r_res);
            r_out_data.overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // assertions
    `GLU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `GLU_ASSERT(a_div_nonzero_divisor, i_clk, i_rst_n, !ctrl.div || (r_g != '0))
    `GLU_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, !ctrl.div || (r_rem < r_g))
    `GLU_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, ctrl.emit, o_out_valid)

endmodule

### hdl/glu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_alu
// shared add / subtract unit with carry and borrow out
// ----------------------------------------------------------------------------
module glu_alu (
    input  logic [glu_pkg::WIDTH:0]   i_op_a,
    input  logic [glu_pkg::WIDTH:0]   i_op_b,
    input  logic                      i_sub,
    output logic [glu_pkg::WIDTH+1:0] o_sum
);
    import glu_pkg::*;

    always_comb begin
        if (i_sub) begin
            o_sum = {1'b0, i_op_a} - {1'b0, i_op_b};
        end else begin
            o_sum = {1'b0, i_op_a} + {1'b0, i_op_b};
        end
    end

endmodule

### hdl/glu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_seq
// sequencer: gcd loop, quotient pass, product pass, result hand-off
// ----------------------------------------------------------------------------
module glu_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  glu_pkg::t_status i_status,
    output glu_pkg::t_ctrl   o_ctrl
);
    import glu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    n_state = i_status.need_div ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (i_status.cnt_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: o_ctrl.load = i_in_valid;
            S_GCD: begin
                o_ctrl.gcd  = 1'b1;
                o_ctrl.busy = 1'b1;
            end
            S_DIV: begin
                o_ctrl.div  = 1'b1;
                o_ctrl.busy = 1'b1;
            end
            S_MUL: begin
                o_ctrl.mul  = 1'b1;
                o_ctrl.busy = 1'b1;
            end
            S_DONE: begin
                o_ctrl.emit = i_status.out_free;
                o_ctrl.busy = 1'b1;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule
